// ===== rtl/tcw_pkg.sv =====
// Shared constants and types for the text console character writer.
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STEP = 4;

  // Character codes with special handling
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_VTAB      = 8'd11;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Colour register reset values
  localparam logic [7:0] RESET_NORMAL_COLOR = 8'hF0;
  localparam logic [7:0] RESET_ERROR_COLOR  = 8'hF4;

  // Request kinds carried on tuser
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam int         CFG_AW           = 1;
  localparam logic [0:0] REG_NORMAL_COLOR = 1'b0;
  localparam logic [0:0] REG_ERROR_COLOR  = 1'b1;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int IDX_W       = 11;
  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 7;
  localparam int OFF_OUT_W   = 11;
  localparam int CELL_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Write decision for one put request
  typedef struct packed {
    logic wr_en;     // a cell is written
    logic wr_blank;  // written cell is a space rather than the character
    logic scroll;    // cursor ran off the last row
  } tcw_put_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_screen_ram.sv =====
// Screen memory: one write port, one registered read port.
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_cursor.sv =====
// Cursor position, row base pointers and screen address mapping.
`default_nettype none

module tcw_cursor
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STEP = DEF_TAB_STEP
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   put_en,
  input  wire logic [CHAR_W-1:0]                      char_code,
  input  wire logic [IDX_W-1:0]                       read_index,
  output tcw_put_t                                    put,
  output logic [$clog2(COLUMNS*ROWS)-1:0]             wr_addr,
  output logic [$clog2(COLUMNS*ROWS)-1:0]             row_base,
  output logic [$clog2(COLUMNS*ROWS)-1:0]             read_addr,
  output logic                                        read_ok,
  output logic [ROW_OUT_W-1:0]                        cursor_row,
  output logic [COL_OUT_W-1:0]                        cursor_column,
  output logic [OFF_OUT_W-1:0]                        cursor_offset
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int XW    = CW + 5;   // room for column plus a tab step
  localparam int SW    = AW + 12;  // read index plus base

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] row_start;  // logical offset of cursor row
  logic [AW-1:0] row_phys;   // physical address of cursor row
  logic [AW-1:0] base_off;   // physical address of logical row 0

  logic [XW-1:0] col_x;
  logic          row_inc;
  logic          row_dec;
  tcw_put_t      put_c;
  logic [AW-1:0] wr_addr_c;
  logic [AW-1:0] phys_up;
  logic [AW-1:0] phys_dn;
  logic [AW-1:0] base_up;
  logic [SW-1:0] rsum;
  logic [SW-1:0] rwrap;
  logic [RW+ROW_OUT_W-1:0] row_x;
  logic [CW+COL_OUT_W-1:0] col_ox;
  logic [AW+OFF_OUT_W-1:0] off_x;

  // cursor movement and target cell for one put request
  always_comb begin
    col_x     = XW'(col);
    row_inc   = 1'b0;
    row_dec   = 1'b0;
    put_c     = '0;
    wr_addr_c = row_phys + AW'(col);
    case (char_code)
      CH_NEWLINE: begin
        col_x   = '0;
        row_inc = 1'b1;
      end
      CH_TAB: begin
        col_x = XW'(col) + XW'(TAB_STEP);
      end
      CH_VTAB: begin
        row_inc = 1'b1;
      end
      CH_RETURN: begin
        col_x = '0;
      end
      CH_BACKSPACE: begin
        if (col == '0) begin
          // at the top-left corner nothing happens
          if (row != '0) begin
            row_dec        = 1'b1;
            col_x          = XW'(COLUMNS - 1);
            put_c.wr_en    = 1'b1;
            put_c.wr_blank = 1'b1;
            wr_addr_c      = (row_phys == '0) ? AW'(CELLS - 1) : row_phys - 1'b1;
          end
        end else begin
          col_x          = XW'(col) - 1'b1;
          put_c.wr_en    = 1'b1;
          put_c.wr_blank = 1'b1;
          wr_addr_c      = row_phys + AW'(col) - 1'b1;
        end
      end
      default: begin
        col_x       = XW'(col) + 1'b1;
        put_c.wr_en = 1'b1;
      end
    endcase
    // line wrap, tab included
    if (col_x >= XW'(COLUMNS)) begin
      col_x   = '0;
      row_inc = 1'b1;
    end
    put_c.scroll = row_inc && (row == RW'(ROWS - 1));
  end

  // circular row pointers
  always_comb begin
    phys_up = (row_phys >= AW'(CELLS - COLUMNS)) ? row_phys - AW'(CELLS - COLUMNS)
                                                 : row_phys + AW'(COLUMNS);
    phys_dn = (row_phys < AW'(COLUMNS)) ? row_phys + AW'(CELLS - COLUMNS)
                                        : row_phys - AW'(COLUMNS);
    base_up = (base_off >= AW'(CELLS - COLUMNS)) ? base_off - AW'(CELLS - COLUMNS)
                                                 : base_off + AW'(COLUMNS);
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      row_start <= '0;
      row_phys  <= '0;
      base_off  <= '0;
    end else if (put_en) begin
      col <= col_x[CW-1:0];
      if (row_inc) begin
        row_phys <= phys_up;
        if (put_c.scroll) begin
          // scroll moves the ring base, the cursor stays on the last row
          base_off <= base_up;
        end else begin
          row       <= row + 1'b1;
          row_start <= row_start + AW'(COLUMNS);
        end
      end else if (row_dec) begin
        row       <= row - 1'b1;
        row_start <= row_start - AW'(COLUMNS);
        row_phys  <= phys_dn;
      end
    end
  end

  // read index to physical address
  always_comb begin
    rsum    = SW'(read_index) + SW'(base_off);
    rwrap   = (rsum >= SW'(CELLS)) ? rsum - SW'(CELLS) : rsum;
    read_ok = SW'(read_index) < SW'(CELLS);
  end

  // result fields, masked to their port widths
  always_comb begin
    row_x  = (RW + ROW_OUT_W)'(row);
    col_ox = (CW + COL_OUT_W)'(col);
    off_x  = (AW + OFF_OUT_W)'(row_start) + (AW + OFF_OUT_W)'(col);
  end

  assign put           = put_c;
  assign wr_addr       = wr_addr_c;
  assign row_base      = row_phys;
  assign read_addr     = rwrap[AW-1:0];
  assign cursor_row    = row_x[ROW_OUT_W-1:0];
  assign cursor_column = col_ox[COL_OUT_W-1:0];
  assign cursor_offset = off_x[OFF_OUT_W-1:0];

  // a scroll leaves the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    put_en && put_c.scroll |=> row == RW'(ROWS - 1))
    else $error("cursor not on last row after scroll");

  // incremental row offset tracks the cursor row, column in range
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    row_start == AW'(32'(row) * COLUMNS) && 32'(col) < COLUMNS)
    else $error("row offset out of step with cursor");

endmodule

`default_nettype wire

// ===== rtl/tcw_top_dummy_placeholder.sv =====
// Request sequencing for the text console writer: clear, blank and result stages.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                accept,
  input  wire logic                                put_scroll,
  input  wire logic                                out_free,
  output logic                                     ready,
  output logic                                     load,
  output logic                                     clearing,
  output logic                                     blanking,
  output logic [$clog2(COLUMNS*ROWS)-1:0]          cnt
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BLANK = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= put_scroll ? ST_BLANK : ST_DONE;
          end
        end
        ST_BLANK: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(COLUMNS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready    = (state == ST_IDLE);
  assign load     = (state == ST_DONE) && out_free;
  assign clearing = (state == ST_CLEAR);
  assign blanking = (state == ST_BLANK);

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !ready)
    else $error("request taken while previous one in progress");

  // results come only from the result stage
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    load |-> $past(state) == ST_IDLE || $past(state) == ST_BLANK
          || $past(state) == ST_DONE)
    else $error("result loaded outside request sequence");

endmodule

`default_nettype wire

// ===== rtl/text_console_char_writer_unit.sv =====
// Text console character writer: a ROWS x COLUMNS screen of 16-bit cells
// (character low byte, colour high byte) with a cursor. After reset the block
// clears the screen memory one cell a cycle and takes no request meanwhile.
// A request is then taken while the block is idle, its result is loaded into
// the output register once that register is free, and the next request is
// taken once that result has moved to the output register. A put that
// scrolls the screen has its result held back while the single write port of
// the screen memory blanks the new bottom line; the scroll itself moves a row
// base pointer so rows are never copied. Colour registers are written with
// cfg_wr_en, cfg_addr and cfg_wdata; the user is to write them only while no
// request is in progress, as the block itself does not enforce this.
`default_nettype none

module text_console_char_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STEP = DEF_TAB_STEP
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // char_code[7:0], error_style[8], read_index[19:9], zero[23:20]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                   s_axis_tuser,
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // cursor_row[4:0], cursor_column[11:5], cursor_offset[22:12],
  // cell_data[38:23], scrolled[39]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // colour register writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [COLOR_W-1:0]     cfg_wdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [COLOR_W-1:0]   normal_color;
  logic [COLOR_W-1:0]   error_color;

  logic [CHAR_W-1:0]    in_char;
  logic                 in_err;
  logic [IDX_W-1:0]     in_idx;
  logic                 accept;
  logic                 put_en;
  logic [COLOR_W-1:0]   color_now;

  tcw_put_t             put;
  logic [AW-1:0]        put_addr;
  logic [AW-1:0]        row_base;
  logic [AW-1:0]        read_addr;
  logic                 read_ok;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_column;
  logic [OFF_OUT_W-1:0] cursor_offset;

  logic                 ready;
  logic                 load;
  logic                 clearing;
  logic                 blanking;
  logic [AW-1:0]        cnt;
  logic                 out_free;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [CELL_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [CELL_W-1:0]    mem_rdata;

  logic [COLOR_W-1:0]   color_lat;
  logic                 is_read;
  logic                 read_hit;
  logic                 scrolled;
  logic [CELL_W-1:0]    cell_data;

  assign in_char   = s_axis_tdata[7:0];
  assign in_err    = s_axis_tdata[8];
  assign in_idx    = s_axis_tdata[19:9];
  assign accept    = s_axis_tvalid && ready;
  assign put_en    = accept && (s_axis_tuser == CMD_PUT);
  assign color_now = in_err ? error_color : normal_color;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_color <= RESET_NORMAL_COLOR;
      error_color  <= RESET_ERROR_COLOR;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_NORMAL_COLOR: normal_color <= cfg_wdata;
        REG_ERROR_COLOR:  error_color  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_cursor (
    .clk           (clk),
    .rst           (rst),
    .put_en        (put_en),
    .char_code     (in_char),
    .read_index    (in_idx),
    .put           (put),
    .wr_addr       (put_addr),
    .row_base      (row_base),
    .read_addr     (read_addr),
    .read_ok       (read_ok),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column),
    .cursor_offset (cursor_offset)
  );

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .put_scroll (put_en && put.scroll),
    .out_free   (out_free),
    .ready      (ready),
    .load       (load),
    .clearing   (clearing),
    .blanking   (blanking),
    .cnt        (cnt)
  );

  assign s_axis_tready = ready;

  // screen write source: clearing pass, bottom line blanking or a put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = put_addr;
    mem_wdata = {color_now, put.wr_blank ? CH_SPACE : in_char};
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wdata = {RESET_NORMAL_COLOR, CH_SPACE};
    end else if (blanking) begin
      mem_we    = 1'b1;
      mem_waddr = row_base + cnt;
      mem_wdata = {color_lat, CH_SPACE};
    end else if (put_en) begin
      mem_we    = put.wr_en;
    end
  end

  assign mem_re = accept && (s_axis_tuser == CMD_READ) && read_ok;

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (read_addr),
    .rdata (mem_rdata)
  );

  // request details kept for the result
  always_ff @(posedge clk) begin
    if (accept) begin
      color_lat <= color_now;
      is_read   <= (s_axis_tuser == CMD_READ);
      read_hit  <= (s_axis_tuser == CMD_READ) && read_ok;
      scrolled  <= put_en && put.scroll;
    end
  end

  assign cell_data = read_hit ? mem_rdata : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {scrolled && !is_read, cell_data, cursor_offset,
                       cursor_column, cursor_row};
    end
  end

  // every screen write lands inside the memory
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_waddr <= AW'(CELLS - 1))
    else $error("screen write address out of range");

  // a new result appears only after a load
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(load))
    else $error("result valid without load");

endmodule

`default_nettype wire

// ===== sim/tb_text_console_char_writer_unit.sv =====
// Self-checking testbench for the text console character writer unit.
`timescale 1ns / 1ps

module tb_text_console_char_writer_unit;
  import tcw_pkg::*;

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int TAB_STEP    = DEF_TAB_STEP;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  // One request as the driver sees it
  typedef struct packed {
    logic             cmd;
    logic [CHAR_W-1:0] ch;
    logic             err;
    logic [IDX_W-1:0] idx;
  } char_req_t;

  // Result word, laid out as on m_axis_tdata (cursor_row in the lowest bits)
  typedef struct packed {
    logic                 scrolled;
    logic [CELL_W-1:0]    cell_word;
    logic [OFF_OUT_W-1:0] offset;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
  } console_result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_LONG_STALL
  } ready_mode_e;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en;
  logic [CFG_AW-1:0]      cfg_addr;
  logic [COLOR_W-1:0]     cfg_wdata;

  // Shadow console state
  logic [CELL_W-1:0]  screen_shadow [0:CELLS-1];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] normal_colour;
  logic [COLOR_W-1:0] error_colour;

  char_req_t       char_requests [$];
  console_result_t console_results [$];

  // Driver / monitor bookkeeping
  logic            req_taken;
  logic            held;
  int              burst_left;
  int              gap_left;
  int              cycle_count;
  int              fail_count;
  char_req_t       seen_req;
  console_result_t predicted;
  console_result_t observed;
  console_result_t wanted;

  // Receiver stall pattern
  ready_mode_e ready_mode;
  int          mode_left;
  int          stall_left;
  logic [7:0]  ready_pattern;

  text_console_char_writer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Apply one request to the shadow console and work out its result
  task automatic console_step(input char_req_t r, output console_result_t res);
    logic [COLOR_W-1:0] colour;
    logic [CELL_W-1:0]  rd_word;
    logic               scr;
    colour  = r.err ? error_colour : normal_colour;
    rd_word = '0;
    scr     = 1'b0;
    if (r.cmd == CMD_READ) begin
      if (r.idx < CELLS) rd_word = screen_shadow[r.idx];
    end else begin
      case (r.ch)
        CH_NEWLINE: begin
          cur_col = 0;
          cur_row++;
        end
        CH_TAB:    cur_col += TAB_STEP;
        CH_VTAB:   cur_row++;
        CH_RETURN: cur_col = 0;
        CH_BACKSPACE: begin
          // nothing to erase at the home position
          if (cur_col != 0 || cur_row != 0) begin
            if (cur_col == 0) begin
              cur_row--;
              cur_col = COLUMNS;
            end
            cur_col--;
            screen_shadow[cur_row * COLUMNS + cur_col] = {colour, CH_SPACE};
          end
        end
        default: begin
          screen_shadow[cur_row * COLUMNS + cur_col] = {colour, r.ch};
          cur_col++;
        end
      endcase
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      // scroll up one line, new bottom line blank in the chosen colour
      if (cur_row >= ROWS) begin
        cur_row = ROWS - 1;
        for (int i = 0; i < CELLS - COLUMNS; i++)
          screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
          screen_shadow[i] = {colour, CH_SPACE};
        scr = 1'b1;
      end
    end
    res.row       = ROW_OUT_W'(cur_row);
    res.col       = COL_OUT_W'(cur_col);
    res.offset    = OFF_OUT_W'(cur_row * COLUMNS + cur_col);
    res.cell_word = rd_word;
    res.scrolled  = scr;
  endtask

  function automatic char_req_t make_req(input logic cmd, input logic [7:0] ch,
                                         input logic err, input logic [10:0] idx);
    char_req_t r;
    r.cmd = cmd;
    r.ch  = ch;
    r.err = err;
    r.idx = idx;
    return r;
  endfunction

  // Weighted random request: mostly puts of a random byte, a fair share of controls and reads
  function automatic char_req_t random_request();
    char_req_t r;
    int        pick;
    r.cmd = CMD_PUT;
    r.ch  = 8'($urandom_range(0, 255));
    r.err = 1'($urandom_range(0, 1));
    r.idx = 11'($urandom_range(0, 2047));
    pick  = $urandom_range(0, 99);
    if (pick < 15) begin
      r.cmd = CMD_READ;
      if (pick < 13) r.idx = 11'($urandom_range(0, CELLS - 1));
    end else if (pick < 25) r.ch = CH_NEWLINE;
    else if (pick < 30) r.ch = CH_TAB;
    else if (pick < 34) r.ch = CH_VTAB;
    else if (pick < 38) r.ch = CH_RETURN;
    else if (pick < 46) r.ch = CH_BACKSPACE;
    return r;
  endfunction

  // Random requests, now and then a run of one put repeated
  task automatic queue_random(input int count);
    char_req_t r;
    int        k;
    int        run;
    k = 0;
    while (k < count) begin
      r = random_request();
      if ($urandom_range(0, 19) == 0) begin
        run   = $urandom_range(3, 40);
        r.cmd = CMD_PUT;
        repeat (run) begin
          char_requests.push_back(r);
          k++;
        end
      end else begin
        char_requests.push_back(r);
        k++;
      end
    end
  endtask

  // Wait until every request is taken and every result has arrived
  task automatic wait_drained();
    while (char_requests.size() != 0 || console_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_colours(input logic [7:0] norm, input logic [7:0] errc);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_NORMAL_COLOR;
    cfg_wdata <= norm;
    @(negedge clk);
    cfg_addr  <= REG_ERROR_COLOR;
    cfg_wdata <= errc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    normal_colour = norm;
    error_colour  = errc;
  endtask

  // Request driver: bursts with random gaps, valid held until taken
  always @(negedge clk) begin
    if (!rst) begin
      held = s_axis_tvalid && !req_taken;
      if (req_taken) begin
        void'(char_requests.pop_front());
        req_taken = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (!held) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: gap_left = 0;
            8:                      gap_left = $urandom_range(9, 25);
            default:                gap_left = $urandom_range(1, 8);
          endcase
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (char_requests.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, char_requests[0].idx, char_requests[0].err,
                            char_requests[0].ch};
          s_axis_tuser  <= char_requests[0].cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall mode picked at random and changed when its run ends
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode    = ready_mode_e'($urandom_range(0, 3));
      mode_left     = $urandom_range(20, 300);
      ready_pattern = 8'($urandom_range(1, 255));
      stall_left    = 0;
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      RDY_PATTERN: begin
        m_axis_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 30);
        end
      end
    endcase
  end

  // Monitor: predict on each taken request, check each taken result
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      seen_req.cmd = s_axis_tuser;
      seen_req.ch  = s_axis_tdata[7:0];
      seen_req.err = s_axis_tdata[8];
      seen_req.idx = s_axis_tdata[19:9];
      console_step(seen_req, predicted);
      console_results.push_back(predicted);
      req_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed = console_result_t'(m_axis_tdata);
      if (console_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: tdata=%h", cycle_count, m_axis_tdata);
      end else begin
        wanted = console_results.pop_front();
        if (observed.row !== wanted.row || observed.col !== wanted.col ||
            observed.offset !== wanted.offset ||
            observed.cell_word !== wanted.cell_word ||
            observed.scrolled !== wanted.scrolled) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: exp row=%0d col=%0d off=%0d cell=%h scr=%b",
                     cycle_count, wanted.row, wanted.col, wanted.offset,
                     wanted.cell_word, wanted.scrolled);
            $display("  got row=%0d col=%0d off=%0d cell=%h scr=%b",
                     observed.row, observed.col, observed.offset,
                     observed.cell_word, observed.scrolled);
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUT;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = REG_NORMAL_COLOR;
    cfg_wdata     = '0;
    req_taken     = 1'b0;
    held          = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    cycle_count   = 0;
    fail_count    = 0;
    mode_left     = 0;
    stall_left    = 0;
    ready_pattern = 8'h5A;
    ready_mode    = RDY_ALWAYS;
    cur_row       = 0;
    cur_col       = 0;
    normal_colour = RESET_NORMAL_COLOR;
    error_colour  = RESET_ERROR_COLOR;
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = {RESET_NORMAL_COLOR, CH_SPACE};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: backspace at home, field extremes, wraps via backspace and tab
    char_requests.push_back(make_req(CMD_PUT, CH_BACKSPACE, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, 8'h41, 1'b1, 11'd2047));
    char_requests.push_back(make_req(CMD_PUT, 8'hFF, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, 8'h00, 1'b1, 11'd1365));
    char_requests.push_back(make_req(CMD_READ, 8'hFF, 1'b1, 11'd0));
    char_requests.push_back(make_req(CMD_READ, 8'h00, 1'b0, 11'd1));
    char_requests.push_back(make_req(CMD_PUT, CH_RETURN, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, CH_VTAB, 1'b0, 11'd0));
    // backspace at column 0 of row 1 lands on the last column of row 0
    char_requests.push_back(make_req(CMD_PUT, CH_BACKSPACE, 1'b1, 11'd0));
    char_requests.push_back(make_req(CMD_READ, 8'h00, 1'b0, 11'd79));
    // tab from the last column wraps to the next line
    char_requests.push_back(make_req(CMD_PUT, CH_TAB, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, CH_BACKSPACE, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, 8'h5A, 1'b0, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, CH_NEWLINE, 1'b1, 11'd0));
    char_requests.push_back(make_req(CMD_PUT, CH_TAB, 1'b1, 11'd0));
    char_requests.push_back(make_req(CMD_READ, 8'h00, 1'b0, 11'd1999));
    char_requests.push_back(make_req(CMD_READ, 8'h00, 1'b0, 11'd2000));
    char_requests.push_back(make_req(CMD_READ, 8'h00, 1'b1, 11'd2047));
    // vertical tabs move the cursor down to row 5
    repeat (3) char_requests.push_back(make_req(CMD_PUT, CH_VTAB, 1'b0, 11'd0));
    queue_random(380);
    wait_drained();

    write_colours(8'h00, 8'hFF);
    queue_random(380);
    wait_drained();

    write_colours(8'hFF, 8'h00);
    queue_random(380);
    wait_drained();

    write_colours(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    queue_random(380);
    wait_drained();

    repeat (COLUMNS + 20) @(negedge clk);
    if (fail_count == 0 && console_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_cursor.sv
rtl/tcw_top_dummy_placeholder.sv
rtl/text_console_char_writer_unit.sv
sim/tb_text_console_char_writer_unit.sv
